/* sv/rmad_pkg.sv */
// Shared types, widths and constant tables for the RSSI moving-average distance block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rmad_pkg;

	// Window length of the moving average (a power of two).
	localparam int WINDOW   = 8;
	localparam int PTR_W    = $clog2(WINDOW);

	// Field and datapath widths.
	localparam int SAMPLE_W = 8;
	localparam int VAL_W    = 9;
	localparam int SUM_W    = 13;
	localparam int AVG_W    = 9;
	localparam int DIST_W   = 15;
	localparam int MAG_W    = 15;
	localparam int DIV_W    = 6;
	localparam int RECIP_W  = 17;
	localparam int RECIP_SHIFT = 20;
	localparam int QUO_W    = 11;
	localparam int PROD_W   = MAG_W + RECIP_W;
	localparam int MODE_W   = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_RSSI_OFFSET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TX_POWER_MODE = 2'd1;

	// Transmit power modes.
	localparam logic [MODE_W-1:0] MODE_MAX     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MID     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIN     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd3;

	// Decoupling queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// One request handed from the front part to the back part.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    filled;
	} rmad_entry_t;

	// Magnitude of the path-loss divisor for each power mode.
	function automatic logic [DIV_W-1:0] divisor_of(input logic [MODE_W-1:0] mode);
		logic [DIV_W-1:0] d;
		unique case (mode)
			MODE_MID: d = 6'd27;
			MODE_MIN: d = 6'd48;
			MODE_MAX, MODE_DEFAULT: d = 6'd16;
			default:  d = 6'd16;
		endcase
		return d;
	endfunction

	// floor(2^RECIP_SHIFT / divisor) for each power mode.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [MODE_W-1:0] mode);
		logic [RECIP_W-1:0] m;
		unique case (mode)
			MODE_MID: m = 17'd38836;
			MODE_MIN: m = 17'd21845;
			MODE_MAX, MODE_DEFAULT: m = 17'd65536;
			default:  m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* sv/rmad_front.sv */
// Front part: accepts RSSI samples, updates the sample ring and the running sum.
// Depends on rmad_pkg; hands one rmad_entry_t per accepted sample to the queue.
`timescale 1ns / 1ps
`default_nettype none

module rmad_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [rmad_pkg::SAMPLE_W-1:0] rssi_sample,
	input  wire logic signed [rmad_pkg::SAMPLE_W-1:0] rssi_offset,
	input  wire logic                              queue_full,
	output logic                                   push,
	output rmad_pkg::rmad_entry_t                  push_entry
);
	import rmad_pkg::*;

	logic signed [VAL_W-1:0] ring_q [WINDOW];
	logic [PTR_W-1:0]        wp_q;
	logic                    filled_q;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [VAL_W-1:0] value;
	logic signed [VAL_W-1:0] oldest;
	logic signed [SUM_W-1:0] sum_next;
	logic                    wrap;
	logic                    filled_next;

	// The sample is taken whenever the queue has room.
	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Offset sample, then replace the oldest ring entry in the running sum.
	always_comb begin
		value       = VAL_W'(rssi_sample) + VAL_W'(rssi_offset);
		oldest      = ring_q[wp_q];
		sum_next    = sum_q - SUM_W'(oldest) + SUM_W'(value);
		wrap        = (wp_q == PTR_W'(WINDOW - 1));
		filled_next = filled_q || wrap;
	end

	assign push_entry.sum    = sum_next;
	assign push_entry.filled = filled_next;

	// Ring, write pointer, fill flag and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			wp_q     <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
		end else if (push) begin
			ring_q[wp_q] <= value;
			wp_q         <= wrap ? '0 : wp_q + 1'b1;
			filled_q     <= filled_next;
			sum_q        <= sum_next;
		end
	end

endmodule

`default_nettype wire

/* sv/rmad_queue.sv */
// Short request queue that decouples the front part from the back part.
// Depends on rmad_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rmad_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  rmad_pkg::rmad_entry_t      push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output logic                       head_valid,
	output rmad_pkg::rmad_entry_t      head_entry
);
	import rmad_pkg::*;

	rmad_entry_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	// Storage slots carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/rmad_back.sv */
// Back part: four-stage pipeline from running sum to average and distance estimate.
// Depends on rmad_pkg; pops requests from rmad_queue and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module rmad_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               head_valid,
	input  rmad_pkg::rmad_entry_t                   head_entry,
	output logic                                    pop,
	input  wire logic [rmad_pkg::MODE_W-1:0]        tx_power_mode,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [rmad_pkg::AVG_W-1:0]       average_rssi,
	output logic                                    average_valid,
	output logic signed [rmad_pkg::DIST_W-1:0]      distance_cm
);
	import rmad_pkg::*;

	localparam logic signed [SUM_W-1:0] WINDOW_S = SUM_W'(WINDOW);

	logic advance;

	// Stage 1: average, its magnitude times 100, divisor selection.
	logic                    v_s1;
	logic signed [AVG_W-1:0] avg_s1;
	logic                    pos_s1;
	logic                    filled_s1;
	logic [MAG_W-1:0]        mag_s1;
	logic [DIV_W-1:0]        div_s1;
	logic [RECIP_W-1:0]      recip_s1;

	// Stage 2: estimated quotient by reciprocal multiply.
	logic                    v_s2;
	logic signed [AVG_W-1:0] avg_s2;
	logic                    pos_s2;
	logic                    filled_s2;
	logic [MAG_W-1:0]        mag_s2;
	logic [DIV_W-1:0]        div_s2;
	logic [QUO_W-1:0]        quo_s2;

	// Stage 3: corrected quotient.
	logic                    v_s3;
	logic signed [AVG_W-1:0] avg_s3;
	logic                    pos_s3;
	logic                    filled_s3;
	logic [QUO_W-1:0]        quo_s3;

	// Stage 4: result register.
	logic                     v_s4;
	logic signed [AVG_W-1:0]  avg_s4;
	logic                     filled_s4;
	logic signed [DIST_W-1:0] dist_s4;

	logic signed [SUM_W-1:0]  avg_wide;
	logic signed [AVG_W-1:0]  avg_c;
	logic [AVG_W-1:0]         abs_c;
	logic [MAG_W-1:0]         abs_w;
	logic [MAG_W-1:0]         mag_c;
	logic [PROD_W-1:0]        prod_c;
	logic [QUO_W+DIV_W-1:0]   qd_c;
	logic [MAG_W-1:0]         rem_c;
	logic [QUO_W-1:0]         quo_c;
	logic [DIST_W-1:0]        ten_c;
	logic signed [DIST_W-1:0] dist_c;

	// The whole pipeline moves when the result register is empty or being taken.
	assign advance = !v_s4 || out_ready;
	assign pop     = advance && head_valid;

	// Average truncated toward zero; zero until the window has filled.
	always_comb begin
		avg_wide = head_entry.sum / WINDOW_S;
		avg_c    = head_entry.filled ? avg_wide[AVG_W-1:0] : '0;
		abs_c    = avg_c[AVG_W-1] ? AVG_W'(-avg_c) : AVG_W'(avg_c);
		abs_w    = MAG_W'(abs_c);
		mag_c    = (abs_w << 6) + (abs_w << 5) + (abs_w << 2);
	end

	// Reciprocal estimate is low by at most one.
	assign prod_c = PROD_W'(mag_s1) * PROD_W'(recip_s1);

	// One compare and increment fixes the estimate.
	always_comb begin
		qd_c  = (QUO_W+DIV_W)'(quo_s2) * (QUO_W+DIV_W)'(div_s2);
		rem_c = mag_s2 - MAG_W'(qd_c);
		quo_c = (rem_c >= MAG_W'(div_s2)) ? quo_s2 + 1'b1 : quo_s2;
	end

	// Times ten, negated for a positive average because the divisor is negative.
	always_comb begin
		ten_c  = (DIST_W'(quo_s3) << 3) + (DIST_W'(quo_s3) << 1);
		dist_c = pos_s3 ? -$signed(ten_c) : $signed(ten_c);
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (advance) begin
			avg_s1    <= avg_c;
			pos_s1    <= !avg_c[AVG_W-1] && (avg_c != '0);
			filled_s1 <= head_entry.filled;
			mag_s1    <= mag_c;
			div_s1    <= divisor_of(tx_power_mode);
			recip_s1  <= recip_of(tx_power_mode);

			avg_s2    <= avg_s1;
			pos_s2    <= pos_s1;
			filled_s2 <= filled_s1;
			mag_s2    <= mag_s1;
			div_s2    <= div_s1;
			quo_s2    <= prod_c[RECIP_SHIFT +: QUO_W];

			avg_s3    <= avg_s2;
			pos_s3    <= pos_s2;
			filled_s3 <= filled_s2;
			quo_s3    <= quo_c;

			avg_s4    <= avg_s3;
			filled_s4 <= filled_s3;
			dist_s4   <= dist_c;
		end
	end

	assign out_valid     = v_s4;
	assign average_rssi  = avg_s4;
	assign average_valid = filled_s4;
	assign distance_cm   = dist_s4;

endmodule

`default_nettype wire

/* sv/rssi_moving_average_distance_top.sv */
// RSSI moving average and distance estimate: one sample per cycle unless stalled.
// A sample is accepted in any cycle in which the four-entry request queue has room;
// the front part updates the eight-entry sample ring and running sum in that cycle,
// and the back part, a four-stage pipeline with one reciprocal multiply and one
// correcting multiply, takes each request from the queue through stages one to
// four. Every accepted sample yields exactly one result. While the result
// output is stalled, up to four further samples are still taken into the queue.
// Configuration writes take effect at the next clock edge and must be made while
// no sample is in flight.
// Depends on rmad_pkg, rmad_front, rmad_queue and rmad_back.
`timescale 1ns / 1ps
`default_nettype none

module rssi_moving_average_distance_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [rmad_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rmad_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [rmad_pkg::SAMPLE_W-1:0]   rssi_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [rmad_pkg::AVG_W-1:0]           average_rssi,
	output logic                                        average_valid,
	output logic signed [rmad_pkg::DIST_W-1:0]          distance_cm
);
	import rmad_pkg::*;

	logic signed [SAMPLE_W-1:0] offset_q;
	logic [MODE_W-1:0]          mode_q;

	logic        push;
	rmad_entry_t push_entry;
	logic        queue_full;
	logic        pop;
	logic        head_valid;
	rmad_entry_t head_entry;

	// Configuration registers; writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			mode_q   <= MODE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RSSI_OFFSET:   offset_q <= $signed(cfg_data[SAMPLE_W-1:0]);
				CFG_TX_POWER_MODE: mode_q   <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	rmad_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rssi_sample (rssi_sample),
		.rssi_offset (offset_q),
		.queue_full  (queue_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	rmad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	rmad_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.tx_power_mode (mode_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.average_rssi  (average_rssi),
		.average_valid (average_valid),
		.distance_cm   (distance_cm)
	);

endmodule

`default_nettype wire
